@@ hdl/nalbw_pkg.sv @@
// ----------------------------------------------------------------------------
// NAL bit writer package
// Shared request and result types and the constants of the escape rule.
// ----------------------------------------------------------------------------
package nalbw_pkg;

   // Default saturation limit for the append length.
   localparam int MAX_FIELD_BITS_DEFAULT = 32;

   // Field widths of a request.
   localparam int FIELD_VALUE_W = 32;
   localparam int FIELD_LEN_W   = 6;

   // Action codes.
   localparam logic ACTION_APPEND = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;

   // Escape byte and the mask that selects bytes of 0x03 or less.
   localparam logic [7:0] ESC_BYTE = 8'h03;
   localparam logic [7:0] ESC_MASK = 8'hfc;

   // Saturation value of the zero-run counter.
   localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

   typedef struct packed {
      logic                     action;
      logic [FIELD_VALUE_W-1:0] field_value;
      logic [FIELD_LEN_W-1:0]   field_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

endpackage

@@ hdl/nal_bit_writer_with_emulation_prevention.sv @@
// ----------------------------------------------------------------------------
// NAL bit writer with emulation prevention
// Packs MSB-first bit fields into bytes, escapes start-code emulation when
// enabled, and finishes each NAL unit with the stop bit and zero padding.
// ----------------------------------------------------------------------------
// A request is registered, then turned combinationally into the full list of
// bytes it causes (up to four data bytes, each possibly preceded by a 0x03
// escape, so at most eight), which is loaded into a result buffer and sent
// one byte per cycle while rsp_stall is low, since the result port carries
// a single byte per cycle. A request that completes no byte leaves the input
// register without waiting for the buffer. The buffer reloads in the
// same cycle its last byte is taken, so there are no bubbles between
// requests. Each byte passes the input register and then the result buffer.
// The last byte caused by a request is flagged with last_of_run.
module nal_bit_writer_with_emulation_prevention #(
   parameter int MAX_FIELD_BITS = nalbw_pkg::MAX_FIELD_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  nalbw_pkg::req_type req_data,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nalbw_pkg::rsp_type rsp_data,
   // Configuration register
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   localparam int MAX_BYTES = (7 + MAX_FIELD_BITS) / 8;
   localparam int MAX_OUT   = 2 * MAX_BYTES;
   localparam int ACC_W     = 8 * (MAX_BYTES + 1);
   localparam int TOT_W     = $clog2(ACC_W + 1);
   localparam int CNT_W     = $clog2(MAX_OUT + 1);
   localparam int IDX_W     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
   localparam int LEN_W     = nalbw_pkg::FIELD_LEN_W;
   localparam int VAL_W     = nalbw_pkg::FIELD_VALUE_W;

   // Registers.
   logic               ep_on_ff, ep_on_in;
   logic               in_valid_ff, in_valid_in;
   nalbw_pkg::req_type in_req_ff, in_req_in;
   logic [6:0]         pend_bits_ff, pend_bits_in;
   logic [2:0]         pend_cnt_ff, pend_cnt_in;
   logic [1:0]         zero_run_ff, zero_run_in;
   logic [7:0]         buf_ff [MAX_OUT];
   logic [7:0]         buf_in [MAX_OUT];
   logic [CNT_W-1:0]   buf_cnt_ff, buf_cnt_in;

   // Combinational results of the registered request.
   logic [LEN_W-1:0]   len;
   logic [VAL_W-1:0]   val;
   logic [ACC_W-1:0]   acc;
   logic [ACC_W-1:0]   left;
   logic [TOT_W-1:0]   total;
   logic [TOT_W-1:0]   nbytes;
   logic [7:0]         fin_byte;
   logic [7:0]         data [MAX_BYTES];
   logic [7:0]         list [MAX_OUT];
   logic [CNT_W-1:0]   nout;
   logic [1:0]         zr_end;
   logic               is_finish;
   logic               is_empty;
   logic               buf_free;
   logic               advance;
   logic               rsp_take;

   // Handshake.
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign buf_free  = (buf_cnt_ff == '0) || ((buf_cnt_ff == CNT_W'(1)) && !rsp_stall);
   assign advance   = in_valid_ff && ((nout == '0) || buf_free);
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid             = (buf_cnt_ff != '0);
   assign rsp_data.out_byte     = buf_ff[0];
   assign rsp_data.last_of_run  = (buf_cnt_ff == CNT_W'(1));

   // Bit packing of the registered request.
   always_comb begin
      is_finish = (in_req_ff.action == nalbw_pkg::ACTION_FINISH);
      if (in_req_ff.field_length > LEN_W'(MAX_FIELD_BITS)) begin
         len = LEN_W'(MAX_FIELD_BITS);
      end else begin
         len = in_req_ff.field_length;
      end
      is_empty = !is_finish && (len == '0);
      val      = in_req_ff.field_value & ~({VAL_W{1'b1}} << len);
      acc      = (ACC_W'(pend_bits_ff) << len) | ACC_W'(val);
      total    = TOT_W'(pend_cnt_ff) + TOT_W'(len);
      left     = acc << (TOT_W'(ACC_W) - total);
      fin_byte = 8'({pend_bits_ff, 1'b1} << (3'd7 - pend_cnt_ff));
      for (int k = 0; k < MAX_BYTES; k++) begin
         data[k] = left[ACC_W-1-8*k -: 8];
      end
      if (is_finish) begin
         data[0] = fin_byte;
         nbytes  = TOT_W'(1);
      end else if (is_empty) begin
         nbytes  = '0;
      end else begin
         nbytes  = total >> 3;
      end
   end

   // Escape insertion and the ordered result list.
   always_comb begin
      logic [1:0]       zr;
      logic [CNT_W-1:0] n;
      zr = zero_run_ff;
      n  = '0;
      for (int i = 0; i < MAX_OUT; i++) begin
         list[i] = '0;
      end
      for (int k = 0; k < MAX_BYTES; k++) begin
         if (TOT_W'(k) < nbytes) begin
            if (!ep_on_ff) begin
               zr = '0;
            end else if ((zr == nalbw_pkg::ZERO_RUN_MAX) &&
                         ((data[k] & nalbw_pkg::ESC_MASK) == '0)) begin
               list[n[IDX_W-1:0]] = nalbw_pkg::ESC_BYTE;
               n  = n + CNT_W'(1);
               zr = '0;
            end
            list[n[IDX_W-1:0]] = data[k];
            n = n + CNT_W'(1);
            if (ep_on_ff) begin
               if (data[k] == '0) begin
                  zr = (zr == nalbw_pkg::ZERO_RUN_MAX) ? zr : zr + 2'd1;
               end else begin
                  zr = '0;
               end
            end
         end
      end
      nout   = n;
      zr_end = zr;
   end

   // Next state of the input register, the packing state and the buffer.
   always_comb begin
      ep_on_in     = csr_wr_en ? csr_wr_data : ep_on_ff;
      in_valid_in  = in_valid_ff;
      in_req_in    = in_req_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      zero_run_in  = zero_run_ff;
      buf_cnt_in   = buf_cnt_ff;
      for (int i = 0; i < MAX_OUT; i++) begin
         buf_in[i] = buf_ff[i];
      end

      // Input register takes a request whenever it is not stalled.
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_req_in = req_data;
         end
      end

      // Taking a result shifts the buffer down by one byte.
      if (rsp_take) begin
         buf_cnt_in = buf_cnt_ff - CNT_W'(1);
         for (int i = 0; i < MAX_OUT - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
      end

      // A request leaves the input register and updates the packing state.
      if (advance) begin
         if (is_finish) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
            zero_run_in  = '0;
         end else if (!is_empty) begin
            pend_cnt_in  = total[2:0];
            pend_bits_in = acc[6:0] & ~(7'h7f << total[2:0]);
            zero_run_in  = zr_end;
         end
         if (nout != '0) begin
            buf_cnt_in = nout;
            for (int i = 0; i < MAX_OUT; i++) begin
               buf_in[i] = list[i];
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ep_on_ff     <= 1'b1;
         in_valid_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         zero_run_ff  <= '0;
         buf_cnt_ff   <= '0;
      end else begin
         ep_on_ff     <= ep_on_in;
         in_valid_ff  <= in_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         zero_run_ff  <= zero_run_in;
         buf_cnt_ff   <= buf_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
      for (int i = 0; i < MAX_OUT; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

endmodule
